>>> sv/dprt_pkg.sv
// Shared types, constants and result codes for the demand page residency tracker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dprt_pkg;

  // Size of the tracked window in pages, and the index width that follows from it.
  localparam int unsigned PAGE_COUNT = 16;
  localparam int unsigned PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // Page geometry: 4 KiB pages, charged as 4 KB each.
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned KB_W       = 7;
  localparam logic [KB_W-1:0] PAGE_KB = KB_W'(4);

  // Field widths.
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned FRAME_W  = 64;
  localparam int unsigned EVIDX_W  = 16;
  localparam int unsigned BUDGET_W = 32;
  localparam int unsigned FAULT_W  = 32;
  localparam int unsigned PGNUM_W  = 4;
  localparam int unsigned CNT_W    = 5;

  // Stream and configuration port widths.
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_KB   = 2'd2;

  // Request kind.
  typedef enum logic {
    ACT_FAULT = 1'b0,
    ACT_EVICT = 1'b1
  } action_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_FAULTED  = 3'd0,
    ST_RESIDENT = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_BUDGET   = 3'd4,
    ST_NOFRAME  = 3'd5,
    ST_EVICTED  = 3'd6,
    ST_NOTRES   = 3'd7
  } status_t;

  // One request as held in the input register.
  typedef struct packed {
    action_t              action;
    logic [ADDR_W-1:0]    fault_address;
    logic                 was_present;
    logic [EVIDX_W-1:0]   evict_index;
    logic [FRAME_W-1:0]   offered_frame;
  } req_t;

  // One result as held in the output register.
  typedef struct packed {
    status_t              status;
    logic                 retry_ok;
    logic [PGNUM_W-1:0]   page_number;
    logic [FRAME_W-1:0]   frame_address;
    logic [CNT_W-1:0]     resident_count;
    logic [KB_W-1:0]      used_kb;
    logic [FAULT_W-1:0]   fault_total;
  } rsp_t;

  // Configuration register contents.
  typedef struct packed {
    logic [ADDR_W-1:0]    region_base;
    logic [ADDR_W-1:0]    region_end;
    logic [BUDGET_W-1:0]  budget_kb;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/dprt_in_reg.sv
// Input register stage: takes one request from the input stream and holds it for evaluation.
// Depends on dprt_pkg for the request layout.
`default_nettype none

module dprt_in_reg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dprt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            advance,
  output logic                                 req_valid,
  output dprt_pkg::req_t                       req
);

  logic           valid_r, valid_nxt;
  dprt_pkg::req_t req_r;
  dprt_pkg::req_t req_unpacked;
  logic           take;

  // The stage refills whenever it is empty or its request moves on this cycle.
  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  // Unpack the stream word into request fields.
  always_comb begin
    req_unpacked.action        = dprt_pkg::action_t'(in_tuser);
    req_unpacked.fault_address = in_tdata[63:0];
    req_unpacked.was_present   = in_tdata[64];
    req_unpacked.evict_index   = in_tdata[80:65];
    req_unpacked.offered_frame = in_tdata[144:81];
  end

  // Occupancy of the stage.
  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= req_unpacked;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

`default_nettype wire

>>> sv/dprt_eval.sv
// Residency state and the single-pass decision for one fault or eviction request.
// Depends on dprt_pkg for types, field widths and status codes.
`default_nettype none

module dprt_eval (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dprt_pkg::cfg_t cfg,
  input  wire logic           fire,
  input  wire dprt_pkg::req_t req,
  output dprt_pkg::rsp_t      rsp
);

  // Tracker state.
  logic [dprt_pkg::PAGE_COUNT-1:0] resident_r, resident_nxt;
  logic [dprt_pkg::FRAME_W-1:0]    frame_r [dprt_pkg::PAGE_COUNT];
  logic [dprt_pkg::KB_W-1:0]       charged_r, charged_nxt;
  logic [dprt_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [dprt_pkg::FAULT_W-1:0]    faults_r, faults_nxt;

  // Decision signals.
  logic                                            in_window;
  logic [dprt_pkg::ADDR_W-1:0]                     offset;
  logic [dprt_pkg::ADDR_W-dprt_pkg::PAGE_SHIFT-1:0] offset_page;
  logic                                            fault_pg_ok;
  logic                                            evict_pg_ok;
  logic [dprt_pkg::PG_W-1:0]                       pg;
  logic                                            pg_ok;
  logic                                            is_resident;
  logic                                            budget_ok;
  logic                                            take_page;
  logic                                            drop_page;
  dprt_pkg::status_t                               status;
  logic                                            report_page;
  logic [dprt_pkg::FRAME_W-1:0]                    frame_out;

  // Window test and page index of a fault.
  assign in_window   = (req.fault_address >= cfg.region_base) &&
                       (req.fault_address < cfg.region_end);
  assign offset      = req.fault_address - cfg.region_base;
  assign offset_page = offset[dprt_pkg::ADDR_W-1:dprt_pkg::PAGE_SHIFT];
  assign fault_pg_ok = offset_page <
                       (dprt_pkg::ADDR_W-dprt_pkg::PAGE_SHIFT)'(dprt_pkg::PAGE_COUNT);
  assign evict_pg_ok = req.evict_index < dprt_pkg::EVIDX_W'(dprt_pkg::PAGE_COUNT);

  // Select the page the request concerns and look it up in the bitmap.
  assign pg          = (req.action == dprt_pkg::ACT_EVICT) ?
                       req.evict_index[dprt_pkg::PG_W-1:0] :
                       offset[dprt_pkg::PAGE_SHIFT +: dprt_pkg::PG_W];
  assign pg_ok       = (req.action == dprt_pkg::ACT_EVICT) ? evict_pg_ok : fault_pg_ok;
  assign is_resident = pg_ok && resident_r[pg];

  // Budget test: another page must fit, computed one bit wider than the budget.
  assign budget_ok = (($bits(cfg.budget_kb)+1)'(charged_r) +
                      ($bits(cfg.budget_kb)+1)'(dprt_pkg::PAGE_KB)) <=
                     ($bits(cfg.budget_kb)+1)'(cfg.budget_kb);

  // Checks in priority order for each request kind.
  always_comb begin
    status      = dprt_pkg::ST_OUTSIDE;
    report_page = 1'b0;
    frame_out   = '0;
    take_page   = 1'b0;
    drop_page   = 1'b0;
    if (req.action == dprt_pkg::ACT_FAULT) begin
      if (!in_window) begin
        status = dprt_pkg::ST_OUTSIDE;
      end else if (req.was_present) begin
        status = dprt_pkg::ST_PRESENT;
      end else if (!fault_pg_ok) begin
        status = dprt_pkg::ST_OUTSIDE;
      end else if (is_resident) begin
        status      = dprt_pkg::ST_RESIDENT;
        report_page = 1'b1;
      end else if (!budget_ok) begin
        status      = dprt_pkg::ST_BUDGET;
        report_page = 1'b1;
      end else if (req.offered_frame == '0) begin
        status      = dprt_pkg::ST_NOFRAME;
        report_page = 1'b1;
      end else begin
        status      = dprt_pkg::ST_FAULTED;
        report_page = 1'b1;
        frame_out   = req.offered_frame;
        take_page   = 1'b1;
      end
    end else begin
      if (!evict_pg_ok) begin
        status = dprt_pkg::ST_NOTRES;
      end else if (!is_resident) begin
        status      = dprt_pkg::ST_NOTRES;
        report_page = 1'b1;
      end else begin
        status      = dprt_pkg::ST_EVICTED;
        report_page = 1'b1;
        frame_out   = frame_r[pg];
        drop_page   = 1'b1;
      end
    end
  end

  // State after this request.
  always_comb begin
    resident_nxt = resident_r;
    charged_nxt  = charged_r;
    count_nxt    = count_r;
    faults_nxt   = faults_r;
    if (take_page) begin
      resident_nxt[pg] = 1'b1;
      charged_nxt      = charged_r + dprt_pkg::PAGE_KB;
      count_nxt        = count_r + 1'b1;
      faults_nxt       = faults_r + 1'b1;
    end else if (drop_page) begin
      resident_nxt[pg] = 1'b0;
      charged_nxt      = charged_r - dprt_pkg::PAGE_KB;
      count_nxt        = count_r - 1'b1;
    end
  end

  // Result fields reflect the state after the step.
  always_comb begin
    rsp.status         = status;
    rsp.retry_ok       = (status inside {dprt_pkg::ST_FAULTED, dprt_pkg::ST_RESIDENT,
                                         dprt_pkg::ST_EVICTED});
    rsp.page_number    = report_page ? dprt_pkg::PGNUM_W'(pg) : '0;
    rsp.frame_address  = frame_out;
    rsp.resident_count = count_nxt;
    rsp.used_kb        = charged_nxt;
    rsp.fault_total    = faults_nxt;
  end

  // Control state commits only when the request moves to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resident_r <= '0;
      charged_r  <= '0;
      count_r    <= '0;
      faults_r   <= '0;
    end else if (fire) begin
      resident_r <= resident_nxt;
      charged_r  <= charged_nxt;
      count_r    <= count_nxt;
      faults_r   <= faults_nxt;
    end
  end

  // Frame table: an entry is only read while its page is resident, so it needs no reset.
  always_ff @(posedge clk) begin
    if (fire && take_page) begin
      frame_r[pg] <= req.offered_frame;
    end
  end

endmodule

`default_nettype wire

>>> sv/demand_page_residency_tracker_core.sv
// Top level of the demand page residency tracker: configuration registers, input stage,
// evaluation and output register. Depends on dprt_pkg, dprt_in_reg and dprt_eval.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/in_tready  tuser: action; tdata: request fields
//   out_     master     out_tvalid/out_tready tuser: status; tdata: result fields
//   cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request is held in the input register and its result is registered in the output
// register; one request per cycle sustained while the output is not stalled.
// The rate is set by the single pass from input register to output register.
// Reset (rst_n low, synchronous) clears the bitmap, counters and configuration.
// A stalled output holds both stages; the input stage still refills while it is empty.
`default_nettype none

module demand_page_residency_tracker_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Request stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [63:0] fault_address, [64] was_present, [80:65] evict_index,
  // [144:81] offered_frame, [151:145] zero
  input  wire logic [dprt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] action
  input  wire logic                              in_tuser,
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] retry_ok, [4:1] page_number, [68:5] frame_address, [73:69] resident_count,
  // [80:74] used_kb, [112:81] fault_total, [119:113] zero
  output logic [dprt_pkg::OUT_DATA_W-1:0]        out_tdata,
  // [2:0] status
  output logic [2:0]                             out_tuser,
  // Configuration writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dprt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dprt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dprt_pkg::cfg_t cfg_r, cfg_nxt;
  logic           advance;
  logic           req_valid;
  dprt_pkg::req_t req;
  dprt_pkg::rsp_t rsp;
  logic           out_valid_r, out_valid_nxt;
  dprt_pkg::rsp_t out_rsp_r;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        dprt_pkg::REG_REGION_BASE: cfg_nxt.region_base = cfg_data;
        dprt_pkg::REG_REGION_END:  cfg_nxt.region_end  = cfg_data;
        dprt_pkg::REG_BUDGET_KB:   cfg_nxt.budget_kb   = cfg_data[dprt_pkg::BUDGET_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The held request moves on whenever the output register is free or being emptied.
  assign advance = !out_valid_r || out_tready;

  dprt_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  dprt_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (req_valid && advance),
    .req   (req),
    .rsp   (rsp)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      out_rsp_r <= rsp;
    end
  end

  // Pack the result onto the stream.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rsp_r.status;
  assign out_tdata  = {7'b0,
                       out_rsp_r.fault_total,
                       out_rsp_r.used_kb,
                       out_rsp_r.resident_count,
                       out_rsp_r.frame_address,
                       out_rsp_r.page_number,
                       out_rsp_r.retry_ok};

endmodule

`default_nettype wire
